FILE: hw/rtl/jgd_pkg.sv
`timescale 1ns / 1ps

package jgd_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned TickW   = 16;
  localparam int unsigned DelayW  = 16;
  localparam int unsigned LevelW  = 10;
  localparam int unsigned SumW    = 11;
  // common width for comparing a tick count against a 16-bit interval
  localparam int unsigned CmpW    = (TickW > DelayW) ? TickW : DelayW;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PosW     = 3;
  localparam int unsigned EvW      = 4;

  localparam int unsigned InW     = 2 * SampleW + 1;
  localparam int unsigned InBytes = (InW + 7) / 8;
  localparam int unsigned InTW    = 8 * InBytes;
  localparam int unsigned OutW     = EvW + PosW;
  localparam int unsigned OutBytes = (OutW + 7) / 8;
  localparam int unsigned OutTW    = 8 * OutBytes;

  typedef enum logic [PosW-1:0] {
    PosCentre = 3'd0,
    PosUp     = 3'd1,
    PosDown   = 3'd2,
    PosLeft   = 3'd3,
    PosRight  = 3'd4
  } pos_e;

  typedef enum logic [EvW-1:0] {
    EvNone  = 4'd0,
    EvClick = 4'd9
  } ev_e;

  localparam logic [EvW-1:0] HoldOffset = 4'd4;

  typedef enum logic [CfgIdxW-1:0] {
    RegDebounce = 3'd0,
    RegHold     = 3'd1,
    RegCentre   = 3'd2,
    RegDeadX    = 3'd3,
    RegDeadY    = 3'd4,
    RegDiagSum  = 3'd5
  } reg_e;

  typedef struct packed {
    logic [LevelW-1:0] centre_level;
    logic [LevelW-1:0] dead_zone_x;
    logic [LevelW-1:0] dead_zone_y;
    logic [SumW-1:0]   diagonal_sum;
  } stick_cfg_t;

endpackage

FILE: hw/rtl/jgd_classify.sv
`timescale 1ns / 1ps

module jgd_classify (
  input  logic [jgd_pkg::SampleW-1:0] x_i,
  input  logic [jgd_pkg::SampleW-1:0] y_i,
  input  jgd_pkg::stick_cfg_t         cfg_i,
  output jgd_pkg::pos_e               pos_o
);

  localparam int unsigned DW = (jgd_pkg::SampleW > jgd_pkg::LevelW) ?
                               jgd_pkg::SampleW : jgd_pkg::LevelW;

  logic [DW-1:0] x_w, y_w, c_w;
  logic [DW-1:0] dist_x, dist_y;
  logic [DW:0]   sum_xy;
  logic [DW:0]   diag_w;
  logic          in_dead, left_up;

  always_comb begin
    x_w    = DW'(x_i);
    y_w    = DW'(y_i);
    c_w    = DW'(cfg_i.centre_level);
    dist_x = (x_w > c_w) ? x_w - c_w : c_w - x_w;
    dist_y = (y_w > c_w) ? y_w - c_w : c_w - y_w;
    sum_xy = {1'b0, x_w} + {1'b0, y_w};
    diag_w = (DW + 1)'(cfg_i.diagonal_sum);
    in_dead = (dist_x < DW'(cfg_i.dead_zone_x)) && (dist_y < DW'(cfg_i.dead_zone_y));
    left_up = sum_xy < diag_w;

    if (in_dead) begin
      pos_o = jgd_pkg::PosCentre;
    end else if (y_w > x_w) begin
      pos_o = left_up ? jgd_pkg::PosLeft : jgd_pkg::PosDown;
    end else begin
      pos_o = left_up ? jgd_pkg::PosUp : jgd_pkg::PosRight;
    end
  end

endmodule

FILE: hw/rtl/joystick_gesture_decoder_unit.sv
`timescale 1ns / 1ps

// Joystick gesture decoder. Each input beat is one timer tick (x sample, y sample,
// active-low button) and gives exactly one output beat (event, current position).
// The block takes one beat per clock: the tick is decoded against the stored state in
// the accepting cycle and the result lands in an output register; a new beat is taken
// whenever that register is empty or being drained, so throughput is one tick per cycle.
// Events: 0 none, 1-4 tap up/down/left/right, 5-8 hold up/down/left/right, 9 click.
// Configuration writes are accepted at any time on the cfg port (index 0 debounce,
// 1 hold time, 2 centre, 3/4 dead zone x/y, 5 diagonal sum) but should only be issued
// while no ticks are in flight.
module joystick_gesture_decoder_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // cfg write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [jgd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [jgd_pkg::CfgDataW-1:0] cfg_data_i,
  // tick stream in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [jgd_pkg::InTW-1:0]     s_axis_tdata,  // x_sample, y_sample, button_level
  // result stream out
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [jgd_pkg::OutTW-1:0]    m_axis_tdata   // event_res, position
);

  localparam int unsigned SW = jgd_pkg::SampleW;
  localparam int unsigned TW = jgd_pkg::TickW;
  localparam int unsigned CW = jgd_pkg::CmpW;

  // configuration
  logic [jgd_pkg::DelayW-1:0] debounce_q, hold_time_q;
  jgd_pkg::stick_cfg_t        stick_cfg_q;

  // decoder state
  jgd_pkg::pos_e  cur_pos_q, cur_pos_d;
  jgd_pkg::pos_e  prev_pos_q, prev_pos_d;
  logic [TW-1:0]  tsu_q, tsu_d;
  logic [TW-1:0]  tsc_q, tsc_d;
  logic           hold_rep_q, hold_rep_d;
  logic           last_btn_q, last_btn_d;

  // output register
  logic                       out_valid_q;
  logic [jgd_pkg::EvW-1:0]    ev_q, ev_d;
  jgd_pkg::pos_e              out_pos_q;

  logic [SW-1:0]  x_in, y_in;
  logic           btn_in;
  logic           in_fire;
  logic [TW-1:0]  tsu_inc, tsc_inc, tsc_chg;
  logic           do_update;
  jgd_pkg::pos_e  cls_pos;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign x_in   = s_axis_tdata[SW-1:0];
  assign y_in   = s_axis_tdata[2*SW-1:SW];
  assign btn_in = s_axis_tdata[2*SW];

  jgd_classify u_classify (
    .x_i   (x_in),
    .y_i   (y_in),
    .cfg_i (stick_cfg_q),
    .pos_o (cls_pos)
  );

  always_comb begin
    tsu_inc   = (tsu_q == '1) ? tsu_q : tsu_q + 1'b1;
    tsc_inc   = (tsc_q == '1) ? tsc_q : tsc_q + 1'b1;
    do_update = CW'(tsu_inc) > CW'(debounce_q);

    cur_pos_d  = cur_pos_q;
    prev_pos_d = cur_pos_q;
    tsu_d      = tsu_inc;
    tsc_d      = tsc_inc;
    hold_rep_d = hold_rep_q;
    last_btn_d = last_btn_q;
    ev_d       = jgd_pkg::EvNone;
    tsc_chg    = tsc_inc;

    if (do_update) begin
      tsu_d = '0;
      if (last_btn_q && !btn_in) begin
        // press edge: click, position left alone
        last_btn_d = 1'b0;
        prev_pos_d = prev_pos_q;
        ev_d       = jgd_pkg::EvClick;
      end else begin
        last_btn_d = btn_in;
        cur_pos_d  = cls_pos;
        tsc_chg    = (cls_pos != prev_pos_q) ? '0 : tsc_inc;
        tsc_d      = tsc_chg;
        prev_pos_d = cls_pos;
        if (CW'(tsc_chg) > CW'(hold_time_q)) begin
          tsc_d      = '0;
          hold_rep_d = 1'b1;
          ev_d       = (cls_pos != jgd_pkg::PosCentre) ?
                       jgd_pkg::EvW'({1'b0, cls_pos}) + jgd_pkg::HoldOffset :
                       jgd_pkg::EvNone;
        end else if (cls_pos == jgd_pkg::PosCentre) begin
          if (prev_pos_q != jgd_pkg::PosCentre && !hold_rep_q) begin
            // tap for the direction just released
            ev_d = jgd_pkg::EvW'({1'b0, prev_pos_q});
          end else begin
            hold_rep_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q               <= 16'd50;
      hold_time_q              <= 16'd1000;
      stick_cfg_q.centre_level <= 10'd500;
      stick_cfg_q.dead_zone_x  <= 10'd100;
      stick_cfg_q.dead_zone_y  <= 10'd150;
      stick_cfg_q.diagonal_sum <= 11'd1000;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        jgd_pkg::RegDebounce: debounce_q <= cfg_data_i;
        jgd_pkg::RegHold:     hold_time_q <= cfg_data_i;
        jgd_pkg::RegCentre:   stick_cfg_q.centre_level <= cfg_data_i[jgd_pkg::LevelW-1:0];
        jgd_pkg::RegDeadX:    stick_cfg_q.dead_zone_x <= cfg_data_i[jgd_pkg::LevelW-1:0];
        jgd_pkg::RegDeadY:    stick_cfg_q.dead_zone_y <= cfg_data_i[jgd_pkg::LevelW-1:0];
        jgd_pkg::RegDiagSum:  stick_cfg_q.diagonal_sum <= cfg_data_i[jgd_pkg::SumW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_pos_q  <= jgd_pkg::PosCentre;
      prev_pos_q <= jgd_pkg::PosCentre;
      tsu_q      <= '0;
      tsc_q      <= '0;
      hold_rep_q <= 1'b0;
      last_btn_q <= 1'b1;
    end else if (in_fire) begin
      cur_pos_q  <= cur_pos_d;
      prev_pos_q <= prev_pos_d;
      tsu_q      <= tsu_d;
      tsc_q      <= tsc_d;
      hold_rep_q <= hold_rep_d;
      last_btn_q <= last_btn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ev_q      <= ev_d;
      out_pos_q <= cur_pos_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = jgd_pkg::OutTW'({out_pos_q, ev_q});

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import jgd_pkg::*;

  typedef struct packed {
    logic               btn;
    logic [SampleW-1:0] y;
    logic [SampleW-1:0] x;
  } tick_t;

  // event in the low bits, position above it
  typedef struct packed {
    pos_e           pos;
    logic [EvW-1:0] ev;
  } gesture_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InTW-1:0]  s_axis_tdata  = '0;  // x_sample, y_sample, button_level
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutTW-1:0] m_axis_tdata;        // event_res, position

  joystick_gesture_decoder_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // decoder mirror: configuration
  logic [DelayW-1:0] debounce_cfg = 16'd50;
  logic [DelayW-1:0] hold_cfg     = 16'd1000;
  logic [LevelW-1:0] centre_cfg   = 10'd500;
  logic [LevelW-1:0] dead_x_cfg   = 10'd100;
  logic [LevelW-1:0] dead_y_cfg   = 10'd150;
  logic [SumW-1:0]   diag_cfg     = 11'd1000;

  // decoder mirror: state
  pos_e             pos_now      = PosCentre;
  pos_e             pos_last     = PosCentre;
  logic [TickW-1:0] since_update = '0;
  logic [TickW-1:0] since_move   = '0;
  logic             hold_seen    = 1'b0;
  logic             button_prev  = 1'b1;

  tick_t       tick_q[$];
  gesture_t    expected_gestures[$];
  int unsigned ticks_queued   = 0;
  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  int unsigned tx_gap_max     = 10;
  int unsigned rx_gap_max     = 10;
  int unsigned stall_requests = 0;

  function automatic int gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic pos_e stick_zone(logic [SampleW-1:0] xs, logic [SampleW-1:0] ys);
    int x, y, c, s;
    x = int'(xs);
    y = int'(ys);
    c = int'(centre_cfg);
    s = x + y;
    if (gap(x, c) < int'(dead_x_cfg) && gap(y, c) < int'(dead_y_cfg)) return PosCentre;
    if (y > x) return (s < int'(diag_cfg)) ? PosLeft : PosDown;
    return (s < int'(diag_cfg)) ? PosUp : PosRight;
  endfunction

  function automatic gesture_t decode_tick(tick_t t);
    gesture_t g;
    g.ev = EvNone;
    if (since_update != '1) since_update = since_update + 1'b1;
    if (since_move != '1) since_move = since_move + 1'b1;
    if (since_update > debounce_cfg) begin
      since_update = '0;
      if (button_prev && !t.btn) begin
        button_prev = 1'b0;
        g.ev = EvClick;
      end else begin
        button_prev = t.btn;
        pos_now = stick_zone(t.x, t.y);
        if (pos_now != pos_last) since_move = '0;
        if (since_move > hold_cfg) begin
          since_move = '0;
          hold_seen  = 1'b1;
          if (pos_now != PosCentre) g.ev = {1'b0, pos_now} + HoldOffset;
        end else if (pos_now == PosCentre) begin
          // tap only when leaving a direction that never reached hold
          if (pos_last != PosCentre && !hold_seen) g.ev = {1'b0, pos_last};
          else hold_seen = 1'b0;
        end
        pos_last = pos_now;
      end
    end else begin
      pos_last = pos_now;
    end
    g.pos = pos_now;
    return g;
  endfunction

  // tick driver
  tick_t       tick_on_bus;
  int unsigned tx_wait = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_gestures.push_back(decode_tick(tick_on_bus));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tick_on_bus = tick_q.pop_front();
          s_axis_tdata  <= InTW'(tick_on_bus);
          s_axis_tvalid <= 1'b1;
          tx_wait = $urandom_range(0, tx_gap_max);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int unsigned rx_wait = 0;
  int unsigned rx_stall = 0;
  int unsigned stalls_started = 0;
  gesture_t    want;
  gesture_t    got;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = gesture_t'(m_axis_tdata[OutW-1:0]);
        results_seen++;
        if (expected_gestures.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: ev=%0d pos=%0d", $time, got.ev, got.pos);
        end else begin
          want = expected_gestures.pop_front();
          if (got.ev !== want.ev) begin
            mismatches++;
            $display("%0t: beat %0d event: expected %0d, actual %0d",
                     $time, results_seen, want.ev, got.ev);
          end
          if (got.pos !== want.pos) begin
            mismatches++;
            $display("%0t: beat %0d position: expected %0d, actual %0d",
                     $time, results_seen, want.pos, got.pos);
          end
        end
        rx_wait = $urandom_range(0, rx_gap_max);
      end
      if (stall_requests != stalls_started) begin
        stalls_started = stall_requests;
        rx_stall = 300;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [SampleW-1:0] clip(int v);
    if (v < 0) return '0;
    if (v > 1023) return 10'd1023;
    return v[SampleW-1:0];
  endfunction

  task automatic queue_tick(int x, int y, logic btn);
    tick_t t;
    t.x   = clip(x);
    t.y   = clip(y);
    t.btn = btn;
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  function automatic int near_centre(logic [LevelW-1:0] dz);
    int d;
    d = int'(dz) - 1;
    if (d <= 0) return int'(centre_cfg);
    return int'(centre_cfg) + int'($urandom_range(0, 2 * d)) - d;
  endfunction

  task automatic queue_noise();
    queue_tick($urandom_range(0, 1023), $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
  endtask

  // mostly: stick out to a point, dwell, back to centre; some noise and broken presses
  task automatic queue_gesture();
    int unsigned kind, len, rest, span, k;
    int px, py;
    kind = $urandom_range(0, 7);
    span = ((debounce_cfg > 6) ? 6 : int'(debounce_cfg)) + 1;
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) queue_noise();
    end else begin
      px  = $urandom_range(0, 1023);
      py  = $urandom_range(0, 1023);
      len = $urandom_range(1, ((hold_cfg > 40) ? 40 : int'(hold_cfg)) + 2 * span + 2);
      for (k = 0; k < len; k++) begin
        if (kind == 1 && k == len / 2) queue_noise();
        else queue_tick(px + int'($urandom_range(0, 4)) - 2, py + int'($urandom_range(0, 4)) - 2,
                        !(kind == 2 && k >= len / 3 && k <= 2 * len / 3));
      end
      rest = $urandom_range(1, 3 * span);
      for (k = 0; k < rest; k++)
        queue_tick(near_centre(dead_x_cfg), near_centre(dead_y_cfg), !(kind == 3 && k < rest / 2));
    end
  endtask

  task automatic fill_gestures(int unsigned n);
    int unsigned start;
    @(negedge clk_i);
    start = ticks_queued;
    while (ticks_queued - start < n) queue_gesture();
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (tick_q.size() != 0 || s_axis_tvalid || expected_gestures.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegDebounce: debounce_cfg = val;
      RegHold:     hold_cfg     = val;
      RegCentre:   centre_cfg   = val[LevelW-1:0];
      RegDeadX:    dead_x_cfg   = val[LevelW-1:0];
      RegDeadY:    dead_y_cfg   = val[LevelW-1:0];
      RegDiagSum:  diag_cfg     = val[SumW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(int deb, int hold, int c, int dx, int dy, int ds,
                           int unsigned txg, int unsigned rxg);
    wait_drained();
    write_reg(RegDebounce, CfgDataW'(deb));
    write_reg(RegHold,     CfgDataW'(hold));
    write_reg(RegCentre,   CfgDataW'(c));
    write_reg(RegDeadX,    CfgDataW'(dx));
    write_reg(RegDeadY,    CfgDataW'(dy));
    write_reg(RegDiagSum,  CfgDataW'(ds));
    tx_gap_max = txg;
    rx_gap_max = rxg;
  endtask

  initial begin
    int unsigned p;
    int deb, hold, c, dx, dy, ds;
    int unsigned g;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration first
    fill_gestures(120);

    configure(0, 3, 500, 100, 150, 1000, 10, 10);
    @(negedge clk_i);
    queue_tick(0, 0, 1'b1);          // up, low corner
    queue_tick(1023, 1023, 1'b1);    // right, high corner
    queue_tick(500, 500, 1'b1);      // back to centre: tap
    queue_tick(0, 1023, 1'b1);       // down
    queue_tick(0, 900, 1'b1);        // left
    queue_tick(500, 500, 1'b1);
    queue_tick(500, 500, 1'b0);      // press: click
    queue_tick(500, 500, 1'b0);      // still pressed, no click
    queue_tick(500, 500, 1'b1);
    repeat (6) queue_tick(0, 0, 1'b1);      // steady up: hold
    queue_tick(500, 500, 1'b1);      // centre after hold: no tap
    repeat (6) queue_tick(500, 500, 1'b1);  // steady centre: silent hold
    queue_tick(599, 500, 1'b1);      // just inside dead zone
    queue_tick(600, 500, 1'b1);      // on the dead zone edge
    queue_tick(300, 699, 1'b1);      // just below diagonal sum
    queue_tick(300, 700, 1'b1);      // on the diagonal sum
    queue_tick(700, 700, 1'b1);      // x equal to y
    queue_tick(200, 200, 1'b1);

    for (p = 0; p < 10; p++) begin
      deb  = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
      hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65534) : $urandom_range(0, 40);
      c    = $urandom_range(0, 1023);
      dx   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 300);
      dy   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 300);
      ds   = $urandom_range(0, 2046);
      g    = (p % 3 == 2) ? 0 : 10;
      case (p)
        0: configure(0, 0, 0, 0, 0, 0, g, g);
        1: configure(0, 65534, 1023, 1023, 1023, 2046, g, g);
        2: configure(1, 0, 0, 1023, 1023, 2046, g, g);
        4: begin
          configure(deb, hold, c, dx, dy, ds, 0, g);
          stall_requests++;
        end
        default: configure(deb, hold, c, dx, dy, ds, g, g);
      endcase
      fill_gestures(200);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
